/* design/mfp_pkg.sv */
// shared types, constants and the crc-8 step function for the motor feedback frame parser
// no dependencies
package mfp_pkg;

  localparam int unsigned DataBytes = 9;
  localparam int unsigned IdxW      = 4;
  localparam logic [7:0]  CrcPoly   = 8'h8C;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CRC   = 2'd1,
    ST_FRAME = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_CURRENT_MODE  = 2'd0,
    REG_SPEED_MODE    = 2'd1,
    REG_POSITION_MODE = 2'd2
  } cfg_reg_t;

  typedef logic [DataBytes-1:0][7:0] frame_bytes_t;

  // tracker view handed to the output stage
  typedef struct packed {
    logic            crc_beat;
    logic [7:0]      crc;
    logic [IdxW-1:0] index;
  } trk_stat_t;

  // reflected crc-8, one byte, eight shift steps
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* design/mfp_frame_track.sv */
// frame position counter, running crc and store of frame bytes 0 to 8
// depends on mfp_pkg
module mfp_frame_track (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 beat,
  input  logic [7:0]           rx_byte,
  input  logic                 restart,
  output mfp_pkg::trk_stat_t   stat,
  output mfp_pkg::frame_bytes_t frame
);

  logic [mfp_pkg::IdxW-1:0] byte_index_r, byte_index_nxt;
  logic [7:0]               crc_r, crc_nxt;
  mfp_pkg::frame_bytes_t    store_r;

  logic [mfp_pkg::IdxW-1:0] idx_eff;
  logic [7:0]               crc_eff;
  logic                     data_beat;

  // a restart byte is always frame byte 0
  assign idx_eff   = restart ? '0 : byte_index_r;
  assign crc_eff   = restart ? '0 : crc_r;
  assign data_beat = idx_eff < mfp_pkg::IdxW'(mfp_pkg::DataBytes);

  always_comb begin
    if (data_beat) begin
      byte_index_nxt = idx_eff + 1'b1;
      crc_nxt        = mfp_pkg::crc8_byte(crc_eff, rx_byte);
    end else begin
      byte_index_nxt = '0;
      crc_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      crc_r        <= '0;
    end else if (beat) begin
      byte_index_r <= byte_index_nxt;
      crc_r        <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat && data_beat) begin
      store_r[idx_eff] <= rx_byte;
    end
  end

  assign stat.crc_beat = !data_beat;
  assign stat.crc      = crc_r;
  assign stat.index    = byte_index_r;
  assign frame         = store_r;

endmodule

/* design/mfp_out_stage.sv */
// crc and mode checks on the crc byte, field decode and the result register
// depends on mfp_pkg
module mfp_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic [7:0]            rx_byte,
  input  mfp_pkg::trk_stat_t    stat,
  input  mfp_pkg::frame_bytes_t frame,
  input  logic [7:0]            current_mode_code,
  input  logic [7:0]            speed_mode_code,
  input  logic [7:0]            position_mode_code,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [87:0]           out_tdata,
  output logic [1:0]            out_tuser
);

  logic             valid_r;
  logic [87:0]      data_r, data_nxt;
  mfp_pkg::status_t status_r, status_nxt;
  logic             mode_ok;

  assign mode_ok = (frame[1] == current_mode_code) || (frame[1] == speed_mode_code) ||
                   (frame[1] == position_mode_code);

  always_comb begin
    if (rx_byte != stat.crc) begin
      status_nxt = mfp_pkg::ST_CRC;
    end else if (!mode_ok) begin
      status_nxt = mfp_pkg::ST_FRAME;
    end else begin
      status_nxt = mfp_pkg::ST_OK;
    end
  end

  // fields from the lowest bit up; all zero on an error result
  always_comb begin
    data_nxt = '0;
    if (status_nxt == mfp_pkg::ST_OK) begin
      data_nxt = {frame[8], frame[7], frame[6], frame[6], frame[7],
                  frame[4], frame[5], frame[2], frame[3], frame[1], frame[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r   <= data_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = status_r;

endmodule

/* design/motor_feedback_frame_parser.sv */
// top level of the motor feedback frame parser: config registers, handshake, checks
// depends on mfp_pkg, mfp_frame_track, mfp_out_stage
//
// Takes one response byte per beat and groups bytes into 10-byte frames; in_tuser high forces
// a byte to be frame byte 0 and drops any partial frame. Bytes 0 to 8 feed a reflected crc-8
// (poly 0x8C, init 0); byte 9 is compared against it and yields one result beat whose
// out_tuser is the status (0 ok, 1 crc mismatch, 2 mode byte matches no configured code) and
// whose fields are all zero unless the status is ok. A byte is taken every cycle but for the
// stall below: the crc step is unrolled between the frame state registers and the result
// register, so byte 9's result is valid in the cycle after it. While a result waits on
// out_tready, data bytes are still accepted; only a byte arriving at frame position 9 (even
// one with restart set) waits for the result register to free up.
module motor_feedback_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] motor_id, [15:8] mode_code, [31:16] torque_current, [47:32] motor_speed,
  // [63:48] position_word, [71:64] temperature, [79:72] position_coarse, [87:80] fault_code
  output logic [87:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0] current_mode_r, speed_mode_r, position_mode_r;
  logic       in_fire;
  logic       load;

  mfp_pkg::trk_stat_t    stat;
  mfp_pkg::frame_bytes_t frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_mode_r  <= 8'd1;
      speed_mode_r    <= 8'd2;
      position_mode_r <= 8'd3;
    end else if (cfg_we) begin
      case (mfp_pkg::cfg_reg_t'(cfg_index))
        mfp_pkg::REG_CURRENT_MODE:  current_mode_r  <= cfg_wdata;
        mfp_pkg::REG_SPEED_MODE:    speed_mode_r    <= cfg_wdata;
        mfp_pkg::REG_POSITION_MODE: position_mode_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stall only when the next byte could be a crc byte and the result slot is busy
  assign in_tready = !out_tvalid || out_tready ||
                     (stat.index < mfp_pkg::IdxW'(mfp_pkg::DataBytes));
  assign in_fire   = in_tvalid && in_tready;
  assign load      = in_fire && stat.crc_beat;

  mfp_frame_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat    (in_fire),
    .rx_byte (in_tdata),
    .restart (in_tuser),
    .stat    (stat),
    .frame   (frame)
  );

  mfp_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (load),
    .rx_byte            (in_tdata),
    .stat               (stat),
    .frame              (frame),
    .current_mode_code  (current_mode_r),
    .speed_mode_code    (speed_mode_r),
    .position_mode_code (position_mode_r),
    .out_tready         (out_tready),
    .out_tvalid         (out_tvalid),
    .out_tdata          (out_tdata),
    .out_tuser          (out_tuser)
  );

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.index <= mfp_pkg::IdxW'(mfp_pkg::DataBytes))
    else $error("frame index past crc byte");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_tvalid)
    else $error("crc byte gave no result");

  a_restart_index: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser |=> stat.index == mfp_pkg::IdxW'(1))
    else $error("restart byte not taken as frame byte 0");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != mfp_pkg::ST_OK) |-> out_tdata == '0)
    else $error("error result carries field data");

endmodule

/* test/mfp_reply_checker.sv */
// reply checker for the motor feedback frame parser: watches both streams and the config port
// depends on mfp_pkg; keeps its own frame tracker and compares each reply beat field by field
`timescale 1ns / 1ps

module mfp_reply_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] restart
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] motor_id, [15:8] mode_code, [31:16] torque_current, [47:32] motor_speed,
  // [63:48] position_word, [71:64] temperature, [79:72] position_coarse, [87:80] fault_code
  input  logic [87:0] out_tdata,
  input  logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    mfp_pkg::status_t   st;
    logic [7:0]         motor_id;
    logic [7:0]         mode;
    logic signed [15:0] current;
    logic signed [15:0] speed;
    logic [15:0]        position;
    logic [7:0]         temperature;
    logic [7:0]         coarse;
    logic [7:0]         fault;
  } reply_t;

  reply_t      replies_due[$];
  logic [3:0]  frame_pos;
  logic [7:0]  crc_run;
  logic [7:0]  frame_buf [mfp_pkg::DataBytes];
  logic [7:0]  mode_current, mode_speed, mode_position;

  // reflected crc-8, one bit per step, lsb first
  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ ((c[0] ^ b[i]) ? mfp_pkg::CrcPoly : 8'h00);
    end
    return c;
  endfunction

  function automatic void cmp(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic restart);
    reply_t r;
    if (restart) begin
      frame_pos = '0;
      crc_run   = '0;
    end
    if (frame_pos < mfp_pkg::DataBytes) begin
      frame_buf[frame_pos] = b;
      crc_run   = crc_step(crc_run, b);
      frame_pos = frame_pos + 4'd1;
    end else begin
      // crc beat (any index of nine or more): one reply, fields only when ok
      r = '0;
      if (b != crc_run) begin
        r.st = mfp_pkg::ST_CRC;
      end else if (frame_buf[1] != mode_current && frame_buf[1] != mode_speed &&
                   frame_buf[1] != mode_position) begin
        r.st = mfp_pkg::ST_FRAME;
      end else begin
        r.st          = mfp_pkg::ST_OK;
        r.motor_id    = frame_buf[0];
        r.mode        = frame_buf[1];
        r.current     = {frame_buf[2], frame_buf[3]};
        r.speed       = {frame_buf[4], frame_buf[5]};
        r.position    = {frame_buf[6], frame_buf[7]};
        r.temperature = frame_buf[6];
        r.coarse      = frame_buf[7];
        r.fault       = frame_buf[8];
      end
      replies_due.push_back(r);
      frame_pos = '0;
      crc_run   = '0;
    end
  endtask

  task automatic check_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      $error("reply beat with no reply due: status %0d data %0h", out_tuser, out_tdata);
      errors++;
    end else begin
      want = replies_due.pop_front();
      cmp("status", 16'(want.st), 16'(out_tuser));
      cmp("motor_id", 16'(want.motor_id), 16'(out_tdata[7:0]));
      cmp("mode_code", 16'(want.mode), 16'(out_tdata[15:8]));
      cmp("torque_current", want.current, out_tdata[31:16]);
      cmp("motor_speed", want.speed, out_tdata[47:32]);
      cmp("position_word", want.position, out_tdata[63:48]);
      cmp("temperature", 16'(want.temperature), 16'(out_tdata[71:64]));
      cmp("position_coarse", 16'(want.coarse), 16'(out_tdata[79:72]));
      cmp("fault_code", 16'(want.fault), 16'(out_tdata[87:80]));
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_pos     = '0;
      crc_run       = '0;
      mode_current  = 8'd1;
      mode_speed    = 8'd2;
      mode_position = 8'd3;
      replies_due.delete();
    end else begin
      if (out_tvalid && out_tready) check_reply();
      if (in_tvalid && in_tready) absorb_byte(in_tdata, in_tuser);
      if (cfg_we) begin
        case (cfg_index)
          mfp_pkg::REG_CURRENT_MODE:  mode_current  = cfg_wdata;
          mfp_pkg::REG_SPEED_MODE:    mode_speed    = cfg_wdata;
          mfp_pkg::REG_POSITION_MODE: mode_position = cfg_wdata;
          default: ;  // unused index, write dropped
        endcase
      end
    end
    pending = replies_due.size();
  end

endmodule

/* test/motor_feedback_frame_parser_tb.sv */
// testbench top for the motor feedback frame parser: clock, reset, byte and config stimulus
// depends on mfp_pkg, motor_feedback_frame_parser and mfp_reply_checker
`timescale 1ns / 1ps

module motor_feedback_frame_parser_tb;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int WATCHDOG      = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid, out_tready;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;
  int          errors, pending;

  int          in_gap_pct = 0;
  int          out_gap_pct = 0;
  bit          hold_req = 1'b0;
  bit          need_resync = 1'b0;
  int          bytes_sent = 0;
  int          idle_cycles = 0;
  logic [7:0]  codes [3] = '{8'd1, 8'd2, 8'd3};

  always #2 clk = ~clk;

  motor_feedback_frame_parser u_top (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  mfp_reply_checker u_chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_index, .cfg_wdata,
    .errors, .pending
  );

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= out_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [7:0] frame_crc(input logic [8:0][7:0] body);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < 9; i++) begin
      c = c ^ body[i];
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ mfp_pkg::CrcPoly) : (c >> 1);
      end
    end
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic restart);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [8:0][7:0] body, input logic [7:0] crc,
                             input logic restart);
    for (int i = 0; i < 9; i++) send_byte(body[i], (i == 0) ? restart : 1'b0);
    send_byte(crc, 1'b0);
  endtask

  // drop valid, let all replies drain, then give the block a few quiet cycles
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_modes(input logic [7:0] cur, input logic [7:0] spd,
                           input logic [7:0] pos);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= mfp_pkg::REG_CURRENT_MODE;
    cfg_wdata <= cur;
    @(posedge clk);
    cfg_index <= mfp_pkg::REG_SPEED_MODE;
    cfg_wdata <= spd;
    @(posedge clk);
    cfg_index <= mfp_pkg::REG_POSITION_MODE;
    cfg_wdata <= pos;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    codes[0] = cur;
    codes[1] = spd;
    codes[2] = pos;
  endtask

  // mostly well-formed frames; some bad mode bytes, bad crc, cut frames and noise
  task automatic random_frame();
    logic [8:0][7:0] body;
    logic [7:0] crc;
    logic       restart;
    int         kind, cut;
    kind = $urandom_range(99);
    for (int i = 0; i < 9; i++) body[i] = 8'($urandom);
    if ($urandom_range(4) == 0) begin
      for (int i = 2; i < 8; i++) begin
        case ($urandom_range(3))
          0: body[i] = 8'h00;
          1: body[i] = 8'hFF;
          2: body[i] = 8'h80;
          default: body[i] = 8'h7F;
        endcase
      end
    end
    if (kind < 55 || kind >= 70) body[1] = codes[$urandom_range(2)];
    crc = frame_crc(body);
    restart = need_resync ? 1'b1 : 1'($urandom_range(1));
    if (kind < 70) begin
      send_packet(body, crc, restart);
      need_resync = 1'b0;
    end else if (kind < 80) begin
      send_packet(body, crc ^ (8'h01 << $urandom_range(7)), restart);
      need_resync = 1'b0;
    end else if (kind < 92) begin
      cut = $urandom_range(9, 1);
      for (int i = 0; i < cut; i++) send_byte(body[i], (i == 0) ? restart : 1'b0);
      need_resync = 1'b1;
    end else begin
      cut = $urandom_range(6, 1);
      for (int i = 0; i < cut; i++) send_byte(8'($urandom), 1'($urandom_range(1)));
      need_resync = 1'b1;
    end
  endtask

  task automatic run_phase(input int sender_pct, input int receiver_pct, input int budget);
    int start;
    in_gap_pct  = sender_pct;
    out_gap_pct = receiver_pct;
    start = bytes_sent;
    while (bytes_sent - start < budget) random_frame();
  endtask

  initial begin
    logic [8:0][7:0] body;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extreme values on a clean frame under the reset mode codes
    body = {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'd3, 8'hFF};
    send_packet(body, frame_crc(body), 1'b0);
    // partial frame cut by a restart, then an unknown mode byte with a good crc
    for (int i = 0; i < 3; i++) send_byte(8'h00, 1'b0);
    body = {8'hFF, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00};
    send_packet(body, frame_crc(body), 1'b1);

    set_modes(8'h00, 8'hFF, 8'h80);
    run_phase(28, 88, 125);
    set_modes(8'h5A, 8'h5A, 8'h5A);
    run_phase(88, 28, 125);
    set_modes(8'($urandom), 8'($urandom), 8'($urandom));
    hold_req = 1'b1;
    run_phase(0, 0, 125);
    wait_idle();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
design/mfp_pkg.sv
design/mfp_frame_track.sv
design/mfp_out_stage.sv
design/motor_feedback_frame_parser.sv
test/mfp_reply_checker.sv
test/motor_feedback_frame_parser_tb.sv
